/* hw/rtl/cst_pkg.sv */
// ----------------------------------------------------------------------------
// cst_pkg: shared types and helpers for the C subset token scanner
// Item structs, token kind codes, character codes and keyword tracking.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int LINE_W   = 16;
  localparam int START_W  = 24;
  localparam int LENGTH_W = 16;

  localparam int DEF_LINE_BITS   = 16;
  localparam int DEF_OFFSET_BITS = 24;
  localparam int DEF_LENGTH_BITS = 16;
  localparam int DEF_QUEUE_DEPTH = 4;

  // token kinds
  localparam logic [3:0] KIND_EOF      = 4'd0;
  localparam logic [3:0] KIND_ERROR    = 4'd1;
  localparam logic [3:0] KIND_CONSTANT = 4'd2;
  localparam logic [3:0] KIND_IDENT    = 4'd3;
  localparam logic [3:0] KIND_LPAREN   = 4'd4;
  localparam logic [3:0] KIND_RPAREN   = 4'd5;
  localparam logic [3:0] KIND_LBRACE   = 4'd6;
  localparam logic [3:0] KIND_RBRACE   = 4'd7;
  localparam logic [3:0] KIND_LBRACKET = 4'd8;
  localparam logic [3:0] KIND_RBRACKET = 4'd9;
  localparam logic [3:0] KIND_SEMI     = 4'd10;
  localparam logic [3:0] KIND_TILDE    = 4'd11;
  localparam logic [3:0] KIND_MINUS    = 4'd12;
  localparam logic [3:0] KIND_INT      = 4'd13;
  localparam logic [3:0] KIND_VOID     = 4'd14;
  localparam logic [3:0] KIND_RETURN   = 4'd15;

  // characters
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_I        = 8'h69;
  localparam logic [7:0] CH_V        = 8'h76;
  localparam logic [7:0] CH_R        = 8'h72;

  // keyword progress: int 1..3, void 4..7, return 8..13; done at last code
  localparam logic [3:0] KW_NONE        = 4'd0;
  localparam logic [3:0] KW_INT_1       = 4'd1;
  localparam logic [3:0] KW_INT_DONE    = 4'd3;
  localparam logic [3:0] KW_VOID_1      = 4'd4;
  localparam logic [3:0] KW_VOID_DONE   = 4'd7;
  localparam logic [3:0] KW_RETURN_1    = 4'd8;
  localparam logic [3:0] KW_RETURN_DONE = 4'd13;

  // next expected character for each progress code, and which codes continue
  localparam logic [7:0] KW_EXPECT [16] = '{
    8'h00, 8'h6E, 8'h74, 8'h00, 8'h6F, 8'h69, 8'h64, 8'h00,
    8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00, 8'h00
  };
  localparam logic [15:0] KW_CONT = 16'h1F76;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          token_kind;
    logic [LINE_W-1:0]   token_line;
    logic [START_W-1:0]  token_start;
    logic [LENGTH_W-1:0] token_length;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [3:0]          kind;
    logic [LINE_W-1:0]   line;
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
  } token_t;

  // all tokens caused by one input item
  typedef struct packed {
    logic [1:0]       last_idx;
    token_t [2:0]     tokens;
  } bundle_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_decimal(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE ||
           c == CH_LBRACKET || c == CH_RBRACKET || c == CH_SEMI || c == CH_TILDE ||
           c == CH_MINUS;
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      CH_LPAREN:   k = KIND_LPAREN;
      CH_RPAREN:   k = KIND_RPAREN;
      CH_LBRACE:   k = KIND_LBRACE;
      CH_RBRACE:   k = KIND_RBRACE;
      CH_LBRACKET: k = KIND_LBRACKET;
      CH_RBRACKET: k = KIND_RBRACKET;
      CH_SEMI:     k = KIND_SEMI;
      CH_TILDE:    k = KIND_TILDE;
      CH_MINUS:    k = KIND_MINUS;
      default:     k = KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] kw_begin(input logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      CH_I:    k = KW_INT_1;
      CH_V:    k = KW_VOID_1;
      CH_R:    k = KW_RETURN_1;
      default: k = KW_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] kw_advance(input logic [3:0] code, input logic [7:0] c);
    if (KW_CONT[code] && c == KW_EXPECT[code]) return code + 4'd1;
    return KW_NONE;
  endfunction

  function automatic logic [3:0] ident_kind(input logic [3:0] code);
    logic [3:0] k;
    unique case (code)
      KW_INT_DONE:    k = KIND_INT;
      KW_VOID_DONE:   k = KIND_VOID;
      KW_RETURN_DONE: k = KIND_RETURN;
      default:        k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/c_subset_token_scanner.sv */
// ----------------------------------------------------------------------------
// c_subset_token_scanner: streaming lexer for a small C subset
// Source bytes in, tokens (kind, line, start offset, length) out.
// ----------------------------------------------------------------------------
// Usage:
//   src channel: one source byte per transfer; end_of_source=1 flushes the
//   pending token and produces EOF. After EOF, bytes are dropped and each
//   further end mark gives another EOF.
//   tok channel: one token per transfer; last_of_run marks the final token
//   caused by one source transfer (a byte may cause zero to three).
// Timing:
//   A byte is taken every cycle while the queue is not full. Each byte's
//   bundle is registered in the queue before its first token is offered
//   on tok. Tokens leave at one per cycle while tok_ready is high; the scan
//   state updates once per byte and does not set the rate.
//   A bundle queue of QUEUE_DEPTH entries sits between scanner and
//   emitter; src_ready drops only while that queue is full.
// Reset (rst, synchronous): line 1, offset 0, no pending token, queue empty.
// A stall on tok_ready backs up into the queue only; scanning continues
// until the queue fills.
// ----------------------------------------------------------------------------
module c_subset_token_scanner #(
  parameter int LINE_BITS   = cst_pkg::DEF_LINE_BITS,
  parameter int OFFSET_BITS = cst_pkg::DEF_OFFSET_BITS,
  parameter int LENGTH_BITS = cst_pkg::DEF_LENGTH_BITS,
  parameter int QUEUE_DEPTH = cst_pkg::DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  cst_pkg::in_item_t  src_item,
  output logic               tok_valid,
  input  logic               tok_ready,
  output cst_pkg::out_item_t tok_item
);
  import cst_pkg::*;

  logic    push, pop, full, empty;
  bundle_t push_bundle, head;

  cst_front #(
    .LINE_BITS  (LINE_BITS),
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_item   (src_item),
    .full       (full),
    .push       (push),
    .push_bundle(push_bundle)
  );

  cst_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_bundle(push_bundle),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  cst_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .tok_valid(tok_valid),
    .tok_ready(tok_ready),
    .tok_item (tok_item)
  );

  // nothing is offered right out of reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !tok_valid)
    else $error("token offered right after reset");

  // EOF always closes its run and has no length
  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_item.token_kind == KIND_EOF |->
      tok_item.last_of_run && tok_item.token_length == '0)
    else $error("malformed EOF token");

  // error tokens are single characters
  a_error_len: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_item.token_kind == KIND_ERROR |-> tok_item.token_length == 16'd1)
    else $error("error token length is not one");

  // a run that is not finished keeps the output valid
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_ready && !tok_item.last_of_run |=> tok_valid)
    else $error("token run cut short");

endmodule

/* hw/rtl/cst_front.sv */
// ----------------------------------------------------------------------------
// cst_front: byte classifier and scan state
// Takes one byte per cycle unless the queue is full, updates the scan state
// and builds the bundle of tokens that the byte completes (up to three).
// ----------------------------------------------------------------------------
module cst_front #(
  parameter int LINE_BITS   = cst_pkg::DEF_LINE_BITS,
  parameter int OFFSET_BITS = cst_pkg::DEF_OFFSET_BITS,
  parameter int LENGTH_BITS = cst_pkg::DEF_LENGTH_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  cst_pkg::in_item_t  src_item,
  input  logic               full,
  output logic               push,
  output cst_pkg::bundle_t   push_bundle
);
  import cst_pkg::*;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_IDENT    = 3'd1;
  localparam logic [2:0] MODE_NUMBER   = 3'd2;
  localparam logic [2:0] MODE_NUMDOT   = 3'd3;
  localparam logic [2:0] MODE_FRACTION = 3'd4;
  localparam logic [2:0] MODE_SLASH    = 3'd5;
  localparam logic [2:0] MODE_COMMENT  = 3'd6;

  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;

  logic [2:0]             mode, mode_next;
  logic [LINE_BITS-1:0]   line_count, line_next;
  logic [OFFSET_BITS-1:0] byte_offset, offset_next;
  logic [OFFSET_BITS-1:0] token_origin, origin_next;
  logic [LENGTH_BITS-1:0] token_count, count_next;
  logic [3:0]             kw_progress, kw_next;
  logic                   finished, finished_next;

  logic                   fire;
  logic [7:0]             c;
  logic [LINE_BITS-1:0]   line_inc;
  logic [OFFSET_BITS-1:0] offset_inc, prev_offset;
  logic [LENGTH_BITS-1:0] count_inc1, count_inc2;

  token_t     f0, f1, t_tok;
  logic [1:0] fcount, fcnt_eff, n_tok;
  logic       do_flush, do_start, t_valid;

  function automatic token_t mk(input logic [3:0] kind, input logic [LINE_BITS-1:0] ln,
                                input logic [OFFSET_BITS-1:0] st,
                                input logic [LENGTH_BITS-1:0] len);
    logic [31:0] lw, sw, nw;
    token_t t;
    lw = 32'(ln);
    sw = 32'(st);
    nw = 32'(len);
    t.kind   = kind;
    t.line   = lw[LINE_W-1:0];
    t.start  = sw[START_W-1:0];
    t.length = nw[LENGTH_W-1:0];
    return t;
  endfunction

  assign src_ready = !full;
  assign fire      = src_valid && src_ready;
  assign c         = src_item.source_byte;

  assign line_inc    = (line_count == '1) ? line_count : line_count + LINE_ONE;
  assign offset_inc  = (byte_offset == '1) ? byte_offset : byte_offset + OFF_ONE;
  assign prev_offset = (byte_offset != '0) ? byte_offset - OFF_ONE : '0;
  assign count_inc1  = (token_count == '1) ? token_count : token_count + LEN_ONE;
  assign count_inc2  = (count_inc1 == '1) ? count_inc1 : count_inc1 + LEN_ONE;

  // tokens released when the pending token is closed
  always_comb begin
    f0     = mk(KIND_CONSTANT, line_count, token_origin, token_count);
    f1     = mk(KIND_ERROR, line_count, prev_offset, LEN_ONE);
    fcount = 2'd0;
    unique case (mode)
      MODE_IDENT: begin
        f0     = mk(ident_kind(kw_progress), line_count, token_origin, token_count);
        fcount = 2'd1;
      end
      MODE_NUMBER, MODE_FRACTION: fcount = 2'd1;
      MODE_NUMDOT:                fcount = 2'd2;
      MODE_SLASH: begin
        f0     = mk(KIND_ERROR, line_count, token_origin, LEN_ONE);
        fcount = 2'd1;
      end
      default: fcount = 2'd0;
    endcase
  end

  always_comb begin
    mode_next     = mode;
    line_next     = line_count;
    offset_next   = byte_offset;
    origin_next   = token_origin;
    count_next    = token_count;
    kw_next       = kw_progress;
    finished_next = finished;
    do_flush      = 1'b0;
    do_start      = 1'b0;
    t_valid       = 1'b0;
    t_tok         = mk(KIND_ERROR, line_count, byte_offset, LEN_ONE);

    if (fire) begin
      if (src_item.end_of_source) begin
        do_flush = !finished;
      end else if (!finished) begin
        offset_next = offset_inc;
        unique case (mode)
          MODE_IDENT: begin
            if (is_letter(c) || is_decimal(c)) begin
              count_next = count_inc1;
              kw_next    = kw_advance(kw_progress, c);
            end else begin
              do_flush = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (is_decimal(c)) begin
              count_next = count_inc1;
            end else if (c == CH_DOT) begin
              mode_next = MODE_NUMDOT;
            end else begin
              do_flush = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_NUMDOT: begin
            if (is_decimal(c)) begin
              count_next = count_inc2;
              mode_next  = MODE_FRACTION;
            end else begin
              do_flush = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_FRACTION: begin
            if (is_decimal(c)) begin
              count_next = count_inc1;
            end else begin
              do_flush = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_SLASH: begin
            if (c == CH_SLASH) begin
              mode_next = MODE_COMMENT;
            end else begin
              do_flush = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_COMMENT: begin
            if (c == CH_LF) begin
              line_next = line_inc;
              mode_next = MODE_IDLE;
            end
          end
          default: do_start = 1'b1;
        endcase
      end

      if (do_flush) begin
        mode_next = MODE_IDLE;
        kw_next   = KW_NONE;
      end

      if (do_start) begin
        mode_next = MODE_IDLE;
        priority if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
          mode_next = MODE_IDLE;
        end else if (c == CH_LF) begin
          line_next = line_inc;
        end else if (c == CH_SLASH) begin
          mode_next   = MODE_SLASH;
          origin_next = byte_offset;
        end else if (is_punct(c)) begin
          t_valid = 1'b1;
          t_tok   = mk(punct_kind(c), line_count, byte_offset, LEN_ONE);
        end else if (is_letter(c)) begin
          mode_next   = MODE_IDENT;
          origin_next = byte_offset;
          count_next  = LEN_ONE;
          kw_next     = kw_begin(c);
        end else if (is_decimal(c)) begin
          mode_next   = MODE_NUMBER;
          origin_next = byte_offset;
          count_next  = LEN_ONE;
        end else begin
          t_valid = 1'b1;
        end
      end

      if (src_item.end_of_source) begin
        t_valid       = 1'b1;
        t_tok         = mk(KIND_EOF, line_count, byte_offset, LEN_ZERO);
        finished_next = 1'b1;
        mode_next     = MODE_IDLE;
      end
    end
  end

  // flushed tokens first, then the token of the byte itself (or EOF)
  assign fcnt_eff = do_flush ? fcount : 2'd0;
  assign n_tok    = fcnt_eff + {1'b0, t_valid};
  assign push     = fire && (n_tok != 2'd0);

  always_comb begin
    push_bundle.last_idx  = n_tok - 2'd1;
    push_bundle.tokens[0] = (fcnt_eff != 2'd0) ? f0 : t_tok;
    push_bundle.tokens[1] = (fcnt_eff == 2'd2) ? f1 : t_tok;
    push_bundle.tokens[2] = t_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      line_count   <= LINE_ONE;
      byte_offset  <= '0;
      token_origin <= '0;
      token_count  <= '0;
      kw_progress  <= KW_NONE;
      finished     <= 1'b0;
    end else begin
      mode         <= mode_next;
      line_count   <= line_next;
      byte_offset  <= offset_next;
      token_origin <= origin_next;
      token_count  <= count_next;
      kw_progress  <= kw_next;
      finished     <= finished_next;
    end
  end

endmodule

/* hw/rtl/cst_queue.sv */
// ----------------------------------------------------------------------------
// cst_queue: token bundle queue
// Small register FIFO between the scanner front and the token emitter.
// ----------------------------------------------------------------------------
module cst_queue #(
  parameter int DEPTH = cst_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cst_pkg::bundle_t push_bundle,
  output logic             full,
  input  logic             pop,
  output cst_pkg::bundle_t head,
  output logic             empty
);
  import cst_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  bundle_t          store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_ONE;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_ONE;
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_ONE;
        2'b01:   count <= count - CNT_ONE;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/cst_back.sv */
// ----------------------------------------------------------------------------
// cst_back: token emitter
// Walks the head bundle one token per transfer and marks the last one.
// ----------------------------------------------------------------------------
module cst_back (
  input  logic               clk,
  input  logic               rst,
  input  cst_pkg::bundle_t   head,
  input  logic               empty,
  output logic               pop,
  output logic               tok_valid,
  input  logic               tok_ready,
  output cst_pkg::out_item_t tok_item
);
  import cst_pkg::*;

  logic [1:0] idx;
  token_t     cur;
  logic       is_last;

  always_comb begin
    unique case (idx)
      2'd0:    cur = head.tokens[0];
      2'd1:    cur = head.tokens[1];
      default: cur = head.tokens[2];
    endcase
  end

  assign is_last   = (idx == head.last_idx);
  assign tok_valid = !empty;
  assign pop       = tok_valid && tok_ready && is_last;

  always_comb begin
    tok_item.token_kind   = cur.kind;
    tok_item.token_line   = cur.line;
    tok_item.token_start  = cur.start;
    tok_item.token_length = cur.length;
    tok_item.last_of_run  = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (tok_valid && tok_ready) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

/* dv/cst_token_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_token_checker: token stream scoreboard for the C subset scanner
// Follows every source transfer with its own scanner model, queues the tokens
// that transfer should produce and compares each token transfer against the
// oldest one, field by field.
// ----------------------------------------------------------------------------
module cst_token_checker
  import cst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  input  logic      src_ready,
  input  in_item_t  src_item,
  input  logic      tok_valid,
  input  logic      tok_ready,
  input  out_item_t tok_item,
  output int        fail_count,
  output int        tokens_due,
  output int        tokens_seen
);

  typedef enum logic [2:0] {
    LEX_IDLE, LEX_WORD, LEX_INTEGER, LEX_DOT, LEX_FRACTION, LEX_SLASH, LEX_COMMENT
  } lex_state_e;

  lex_state_e          lex_state;
  logic [LINE_W-1:0]   cur_line;
  logic [START_W-1:0]  cur_offset;
  logic [START_W-1:0]  tok_begin;
  logic [LENGTH_W-1:0] tok_len;
  logic [7:0]          word_head [6];
  logic                ended;

  out_item_t expected_tokens [$];

  initial begin
    fail_count  = 0;
    tokens_seen = 0;
    tokens_due  = 0;
  end

  task automatic report_mismatch(input string msg);
    // keep the log short on a broken design; every failure is still counted
    if (fail_count < 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic decimal_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [LINE_W-1:0] bump_line(input logic [LINE_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [LENGTH_W-1:0] bump_len(input logic [LENGTH_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // keywords only on exact spelling and length
  function automatic logic [3:0] word_kind();
    if (tok_len == 3 && {word_head[0], word_head[1], word_head[2]} == "int")
      return KIND_INT;
    if (tok_len == 4 && {word_head[0], word_head[1], word_head[2], word_head[3]} == "void")
      return KIND_VOID;
    if (tok_len == 6 && {word_head[0], word_head[1], word_head[2], word_head[3],
                         word_head[4], word_head[5]} == "return")
      return KIND_RETURN;
    return KIND_IDENT;
  endfunction

  task automatic push_token(input logic [3:0] kind, input logic [START_W-1:0] start,
                            input logic [LENGTH_W-1:0] len);
    out_item_t t;
    t.token_kind   = kind;
    t.token_line   = cur_line;
    t.token_start  = start;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    expected_tokens.push_back(t);
  endtask

  task automatic close_token();
    case (lex_state)
      LEX_WORD:                  push_token(word_kind(), tok_begin, tok_len);
      LEX_INTEGER, LEX_FRACTION: push_token(KIND_CONSTANT, tok_begin, tok_len);
      LEX_DOT: begin
        // digits then a dot with no fraction: constant plus an error on the dot
        push_token(KIND_CONSTANT, tok_begin, tok_len);
        push_token(KIND_ERROR, (cur_offset != 0) ? cur_offset - 1'b1 : '0, 1);
      end
      LEX_SLASH:                 push_token(KIND_ERROR, tok_begin, 1);
      default: ;
    endcase
    lex_state = LEX_IDLE;
  endtask

  task automatic open_token(input logic [7:0] c);
    lex_state = LEX_IDLE;
    case (c)
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_LF:       cur_line = bump_line(cur_line);
      CH_SLASH: begin
        lex_state = LEX_SLASH;
        tok_begin = cur_offset;
      end
      CH_LPAREN:   push_token(KIND_LPAREN, cur_offset, 1);
      CH_RPAREN:   push_token(KIND_RPAREN, cur_offset, 1);
      CH_LBRACE:   push_token(KIND_LBRACE, cur_offset, 1);
      CH_RBRACE:   push_token(KIND_RBRACE, cur_offset, 1);
      CH_LBRACKET: push_token(KIND_LBRACKET, cur_offset, 1);
      CH_RBRACKET: push_token(KIND_RBRACKET, cur_offset, 1);
      CH_SEMI:     push_token(KIND_SEMI, cur_offset, 1);
      CH_TILDE:    push_token(KIND_TILDE, cur_offset, 1);
      CH_MINUS:    push_token(KIND_MINUS, cur_offset, 1);
      default: begin
        if (word_char(c)) begin
          lex_state    = LEX_WORD;
          tok_begin    = cur_offset;
          tok_len      = 1;
          word_head[0] = c;
        end else if (decimal_char(c)) begin
          lex_state = LEX_INTEGER;
          tok_begin = cur_offset;
          tok_len   = 1;
        end else begin
          push_token(KIND_ERROR, cur_offset, 1);
        end
      end
    endcase
  endtask

  task automatic scan_text_byte(input logic [7:0] c);
    case (lex_state)
      LEX_WORD: begin
        if (word_char(c) || decimal_char(c)) begin
          if (tok_len < 6) word_head[tok_len] = c;
          tok_len = bump_len(tok_len);
        end else begin
          close_token();
          open_token(c);
        end
      end
      LEX_INTEGER: begin
        if (decimal_char(c)) begin
          tok_len = bump_len(tok_len);
        end else if (c == CH_DOT) begin
          lex_state = LEX_DOT;
        end else begin
          close_token();
          open_token(c);
        end
      end
      LEX_DOT: begin
        if (decimal_char(c)) begin
          // the dot and the first fraction digit both count
          tok_len   = bump_len(bump_len(tok_len));
          lex_state = LEX_FRACTION;
        end else begin
          close_token();
          open_token(c);
        end
      end
      LEX_FRACTION: begin
        if (decimal_char(c)) begin
          tok_len = bump_len(tok_len);
        end else begin
          close_token();
          open_token(c);
        end
      end
      LEX_SLASH: begin
        if (c == CH_SLASH) begin
          lex_state = LEX_COMMENT;
        end else begin
          close_token();
          open_token(c);
        end
      end
      LEX_COMMENT: begin
        if (c == CH_LF) begin
          cur_line  = bump_line(cur_line);
          lex_state = LEX_IDLE;
        end
      end
      default: open_token(c);
    endcase
    if (!(&cur_offset)) cur_offset = cur_offset + 1'b1;
  endtask

  task automatic predict_tokens(input in_item_t it);
    int        queued;
    out_item_t tail;
    queued = expected_tokens.size();
    if (it.end_of_source) begin
      if (!ended) close_token();
      push_token(KIND_EOF, cur_offset, 0);
      ended     = 1'b1;
      lex_state = LEX_IDLE;
    end else if (!ended) begin
      scan_text_byte(it.source_byte);
    end
    if (expected_tokens.size() > queued) begin
      tail = expected_tokens.pop_back();
      tail.last_of_run = 1'b1;
      expected_tokens.push_back(tail);
    end
  endtask

  task automatic check_token(input out_item_t got);
    out_item_t want;
    tokens_seen++;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected token kind %0d line %0d start %0d len %0d",
                                got.token_kind, got.token_line, got.token_start,
                                got.token_length));
      return;
    end
    want = expected_tokens.pop_front();
    if (got.token_kind !== want.token_kind)
      report_mismatch($sformatf("token %0d kind: got %0d, expected %0d",
                                tokens_seen, got.token_kind, want.token_kind));
    if (got.token_line !== want.token_line)
      report_mismatch($sformatf("token %0d line: got %0d, expected %0d",
                                tokens_seen, got.token_line, want.token_line));
    if (got.token_start !== want.token_start)
      report_mismatch($sformatf("token %0d start: got %0d, expected %0d",
                                tokens_seen, got.token_start, want.token_start));
    if (got.token_length !== want.token_length)
      report_mismatch($sformatf("token %0d length: got %0d, expected %0d",
                                tokens_seen, got.token_length, want.token_length));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch($sformatf("token %0d last_of_run: got %0b, expected %0b",
                                tokens_seen, got.last_of_run, want.last_of_run));
  endtask

  // predict before compare so the queue stays in transfer order
  always @(posedge clk) begin
    if (rst) begin
      lex_state  = LEX_IDLE;
      cur_line   = 1;
      cur_offset = '0;
      tok_begin  = '0;
      tok_len    = '0;
      ended      = 1'b0;
      expected_tokens.delete();
      tokens_due <= 0;
    end else begin
      if (src_valid && src_ready) predict_tokens(src_item);
      if (tok_valid && tok_ready) check_token(tok_item);
      tokens_due <= expected_tokens.size();
    end
  end

endmodule

/* dv/c_subset_token_scanner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_token_scanner_tb: top level test for the C subset token scanner
// Feeds directed text, random token-shaped text with noise and a flush at
// end of text, with random gaps on both channels; the checker scores every
// token.
// ----------------------------------------------------------------------------
module c_subset_token_scanner_tb;
  import cst_pkg::*;

  localparam int RANDOM_ITEMS = 415;
  localparam int IDLE_PCT     = 26;

  logic      clk = 1'b0;
  logic      rst;
  logic      src_valid;
  logic      src_ready;
  in_item_t  src_item;
  logic      tok_valid;
  logic      tok_ready;
  out_item_t tok_item;

  int        fail_count;
  int        tokens_due;
  int        tokens_seen;
  int        idle_pct = IDLE_PCT;
  int        bytes_sent = 0;
  string     tail_case;

  always #1 clk = ~clk;

  c_subset_token_scanner dut (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_item (src_item),
    .tok_valid(tok_valid),
    .tok_ready(tok_ready),
    .tok_item (tok_item)
  );

  cst_token_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_item   (src_item),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok_item   (tok_item),
    .fail_count (fail_count),
    .tokens_due (tokens_due),
    .tokens_seen(tokens_seen)
  );

  // token side back-pressure
  initial begin
    tok_ready = 1'b0;
    forever begin
      @(negedge clk);
      tok_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic [7:0] b, input logic eos);
    in_item_t it;
    it.source_byte   = b;
    it.end_of_source = eos;
    while ($urandom_range(0, 99) < idle_pct) begin
      src_valid <= 1'b0;
      src_item  <= in_item_t'($urandom);
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    do @(posedge clk); while (!src_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // one random piece of source text: mostly well-formed tokens, some noise
  task automatic send_fragment();
    string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string punct = "(){}[];~-";
    string seps  = " ;(\n\t\r";
    string blank = " \t\r\n";
    string words [3] = '{"int", "void", "return"};
    string near_words [10] = '{"in", "voi", "retur", "intx", "void_", "returns",
                               "i", "Int", "VOID", "r9"};
    int         pick;
    int         n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_text(words[$urandom_range(0, 2)]);
      if ($urandom_range(0, 9) < 7) send_item(seps[$urandom_range(0, seps.len() - 1)], 1'b0);
    end else if (pick < 20) begin
      send_text(near_words[$urandom_range(0, 9)]);
    end else if (pick < 38) begin
      send_item(alnum[$urandom_range(0, 52)], 1'b0);
      n = $urandom_range(0, 7);
      repeat (n) send_item(alnum[$urandom_range(0, alnum.len() - 1)], 1'b0);
    end else if (pick < 52) begin
      n = $urandom_range(1, 4);
      repeat (n) send_item(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        send_item(CH_DOT, 1'b0);
        n = $urandom_range(1, 3);
        repeat (n) send_item(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
      end else if (pick == 4) begin
        send_item(CH_DOT, 1'b0);
      end
    end else if (pick < 68) begin
      send_item(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
    end else if (pick < 80) begin
      send_item(blank[$urandom_range(0, 3)], 1'b0);
    end else if (pick < 86) begin
      send_text("//");
      n = $urandom_range(0, 8);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_LF) b = CH_SPACE;
        send_item(b, 1'b0);
      end
      if ($urandom_range(0, 9) != 0) send_item(CH_LF, 1'b0);
    end else if (pick < 90) begin
      send_item(CH_SLASH, 1'b0);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    int random_base;
    rst       = 1'b1;
    src_valid = 1'b0;
    src_item  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: keywords, near misses, lone slash, comment, dot cases, extremes
    send_text("int void return intx/;2.x//\n1.5");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b0);
    send_text("_Z9)");

    random_base = bytes_sent;
    while (bytes_sent - random_base < RANDOM_ITEMS) begin
      // a stretch with no gaps on either side
      if (bytes_sent - random_base >= 150 && bytes_sent - random_base < 270)
        idle_pct = 0;
      else
        idle_pct = IDLE_PCT;
      send_fragment();
    end
    idle_pct = IDLE_PCT;

    // end of text with a random token still pending
    case ($urandom_range(0, 6))
      0: begin tail_case = "identifier"; send_text("ab"); end
      1: begin tail_case = "number"; send_text("12"); end
      2: begin tail_case = "number with bare dot"; send_text("7."); end
      3: begin tail_case = "fraction"; send_text("7.5"); end
      4: begin tail_case = "lone slash"; send_text("/"); end
      5: begin tail_case = "comment"; send_text("//zz"); end
      default: begin tail_case = "no pending token"; send_text(" "); end
    endcase
    send_item(8'($urandom_range(0, 255)), 1'b1);
    // ignored after end, then repeated end marks
    repeat (8) send_item(8'($urandom_range(0, 255)), 1'b0);
    repeat (2) send_item(8'($urandom_range(0, 255)), 1'b1);
    src_valid <= 1'b0;

    while (tokens_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d source transfers, checked %0d tokens: directed text, random text,",
             bytes_sent, tokens_seen);
    $display("a gap-free stretch, end of text with %s, bytes and end marks after EOF.",
             tail_case);
    if (fail_count == 0 && tokens_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Timeout with %0d tokens outstanding", tokens_due);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cst_pkg.sv
hw/rtl/cst_front.sv
hw/rtl/cst_queue.sv
hw/rtl/cst_back.sv
hw/rtl/c_subset_token_scanner.sv
dv/cst_token_checker.sv
dv/c_subset_token_scanner_tb.sv
